FILE: rtl/core/ifcm_pkg.sv
// Shared types and constants for the intensity false-color map unit.
// Used by the divider, gamma and color stages, the top level and the monitor.
// No dependencies.
package ifcm_pkg;

   // Fixed widths of the pixel, register and color fields.
   localparam int INTENSITY_WIDTH = 25;
   localparam int MAX_WIDTH       = 24;
   localparam int CHANNEL_WIDTH   = 8;
   localparam int CSR_ADDR_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   // Channel levels used by the fixed colors.
   localparam logic [CHANNEL_WIDTH-1:0] CHANNEL_FULL = 8'hFF;
   localparam logic [CHANNEL_WIDTH-1:0] CHANNEL_ZERO = 8'h00;

   // Slope of one color segment: four segments of one quarter each span 255 levels.
   localparam int COLOR_SLOPE = 1020;
   localparam int SLOPE_WIDTH = 10;
   localparam int LEVEL_WIDTH = SLOPE_WIDTH + 1;

   // Register indexes on the configuration port.
   typedef enum logic {
      CSR_MAX_INTENSITY = 1'b0,
      CSR_GAMMA_CURVE   = 1'b1
   } ifcm_csr_index_type;

   // Linear segments of the color ramp.
   typedef enum logic [1:0] {
      SEG_RED_RISE,
      SEG_GREEN_RISE,
      SEG_BLUE_RISE,
      SEG_WHITE_RISE
   } ifcm_segment_type;

   // Special-value flags that travel with each pixel through the pipeline.
   typedef struct packed {
      logic is_nan;
      logic is_inf;
   } ifcm_tag_type;

endpackage

FILE: rtl/core/ifcm_div.sv
// Pipelined restoring divider that forms the Q1.FRACTION_BITS intensity ratio.
// One quotient bit per stage; depends on ifcm_pkg.
module ifcm_div
   import ifcm_pkg::*;
#(
   parameter int FRACTION_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  ifcm_tag_type               in_tag,
   input  logic [INTENSITY_WIDTH-1:0] in_intensity,
   input  logic [MAX_WIDTH-1:0]       max_intensity,
   output logic                       out_valid,
   output ifcm_tag_type               out_tag,
   output logic [FRACTION_BITS:0]     out_ratio
);

   localparam int Steps      = FRACTION_BITS;
   localparam int RatioWidth = FRACTION_BITS + 1;
   localparam int RemWidth   = MAX_WIDTH;

   logic                  valid_ff [Steps+1];
   ifcm_tag_type          tag_ff   [Steps+1];
   logic                  zero_ff  [Steps+1];
   logic                  full_ff  [Steps+1];
   logic [RemWidth-1:0]   rem_ff   [Steps];
   logic [RatioWidth-1:0] quot_ff  [Steps+1];

   logic [RemWidth-1:0] raw;
   logic                lead_bit_in;
   logic [RemWidth-1:0] rem_in;
   logic                zero_in;
   logic                full_in;

   // Entry stage: the integer quotient bit, the clamp to zero and the saturation check.
   // The ratio saturates exactly when the intensity reaches twice the maximum.
   always_comb begin
      raw         = in_intensity[RemWidth-1:0];
      lead_bit_in = raw >= max_intensity;
      rem_in      = lead_bit_in ? raw - max_intensity : raw;
      zero_in     = in_intensity[INTENSITY_WIDTH-1] || (max_intensity == '0);
      full_in     = {1'b0, raw} >= {max_intensity, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff[0]  <= in_tag;
      zero_ff[0] <= zero_in;
      full_ff[0] <= full_in;
      rem_ff[0]  <= rem_in;
      quot_ff[0] <= RatioWidth'(lead_bit_in);
   end

   // One fraction bit per stage: shift the remainder and try to subtract the maximum.
   for (genvar k = 0; k < Steps; k++) begin : g_step
      logic [RemWidth:0]   twice_rem;
      logic [RemWidth+1:0] diff;
      logic                quot_bit_in;

      always_comb begin
         twice_rem   = {rem_ff[k], 1'b0};
         diff        = {1'b0, twice_rem} - {2'b00, max_intensity};
         quot_bit_in = ~diff[RemWidth+1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         tag_ff[k+1]  <= tag_ff[k];
         zero_ff[k+1] <= zero_ff[k];
         full_ff[k+1] <= full_ff[k];
         quot_ff[k+1] <= {quot_ff[k][RatioWidth-2:0], quot_bit_in};
      end

      // The last stage needs no remainder.
      if (k < Steps - 1) begin : g_rem
         always_ff @(posedge clock) begin
            rem_ff[k+1] <= quot_bit_in ? diff[RemWidth-1:0] : twice_rem[RemWidth-1:0];
         end
      end
   end

   // Apply the clamps to the finished quotient.
   always_comb begin
      out_valid = valid_ff[Steps];
      out_tag   = tag_ff[Steps];
      if (zero_ff[Steps]) begin
         out_ratio = '0;
      end else if (full_ff[Steps]) begin
         out_ratio = '1;
      end else begin
         out_ratio = quot_ff[Steps];
      end
   end

endmodule

FILE: rtl/core/ifcm_gamma.sv
// Optional power-0.6 curve applied to the ratio through a lookup table.
// Two stages: table index, then registered table read; depends on ifcm_pkg.
module ifcm_gamma
   import ifcm_pkg::*;
#(
   parameter int FRACTION_BITS     = 16,
   parameter int GAMMA_TABLE_DEPTH = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   gamma_curve,
   input  logic                   in_valid,
   input  ifcm_tag_type           in_tag,
   input  logic [FRACTION_BITS:0] in_ratio,
   output logic                   out_valid,
   output ifcm_tag_type           out_tag,
   output logic [FRACTION_BITS:0] out_ratio
);

   localparam int RatioWidth     = FRACTION_BITS + 1;
   localparam int DepthWidth     = $clog2(GAMMA_TABLE_DEPTH + 1);
   localparam int IndexWidth     = $clog2(GAMMA_TABLE_DEPTH);
   localparam int ProdWidth      = RatioWidth + DepthWidth;
   localparam int IndexFullWidth = ProdWidth - FRACTION_BITS;
   localparam int CalcWidth      = 5 * FRACTION_BITS + 3 * DepthWidth + 8;

   localparam logic [ProdWidth-1:0]      DepthScale = ProdWidth'(GAMMA_TABLE_DEPTH);
   localparam logic [IndexFullWidth-1:0] DepthLimit = IndexFullWidth'(GAMMA_TABLE_DEPTH);
   localparam logic [RatioWidth-1:0]     RatioOne   = RatioWidth'(1) << FRACTION_BITS;

   typedef logic [FRACTION_BITS-1:0] gamma_rom_type [GAMMA_TABLE_DEPTH];

   // Entry i is the largest y with (y / 2^F)^5 <= (i / depth)^3, found bit by bit.
   function automatic gamma_rom_type build_gamma_rom();
      gamma_rom_type            rom;
      logic [CalcWidth-1:0]     lhs;
      logic [CalcWidth-1:0]     rhs;
      logic [CalcWidth-1:0]     trial;
      logic [CalcWidth-1:0]     index_val;
      logic [CalcWidth-1:0]     depth_val;
      logic [FRACTION_BITS-1:0] y;
      depth_val = CalcWidth'(GAMMA_TABLE_DEPTH);
      for (int i = 0; i < GAMMA_TABLE_DEPTH; i++) begin
         index_val = CalcWidth'(i);
         rhs       = (index_val * index_val * index_val) << (5 * FRACTION_BITS);
         y         = '0;
         for (int b = FRACTION_BITS - 1; b >= 0; b--) begin
            trial = CalcWidth'(y) | (CalcWidth'(1) << b);
            lhs   = trial * trial * trial * trial * trial * depth_val * depth_val * depth_val;
            if (lhs <= rhs) begin
               y = trial[FRACTION_BITS-1:0];
            end
         end
         rom[i] = y;
      end
      return rom;
   endfunction

   localparam gamma_rom_type GammaRom = build_gamma_rom();

   logic [ProdWidth-1:0]      index_prod;
   logic [IndexFullWidth-1:0] index_full;
   logic                      past_end_in;

   logic                     valid_a_ff;
   ifcm_tag_type             tag_a_ff;
   logic [RatioWidth-1:0]    ratio_a_ff;
   logic [IndexWidth-1:0]    index_ff;
   logic                     past_end_a_ff;

   logic                     valid_b_ff;
   ifcm_tag_type             tag_b_ff;
   logic [RatioWidth-1:0]    ratio_b_ff;
   logic                     past_end_b_ff;
   logic [FRACTION_BITS-1:0] rom_data_ff;

   // Table index: ratio scaled by the depth; a ratio of one or more runs past the end.
   always_comb begin
      index_prod  = ProdWidth'(in_ratio) * DepthScale;
      index_full  = index_prod[ProdWidth-1:FRACTION_BITS];
      past_end_in = index_full >= DepthLimit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      tag_a_ff      <= in_tag;
      ratio_a_ff    <= in_ratio;
      index_ff      <= index_full[IndexWidth-1:0];
      past_end_a_ff <= past_end_in;
   end

   // Registered table read.
   always_ff @(posedge clock) begin
      tag_b_ff      <= tag_a_ff;
      ratio_b_ff    <= ratio_a_ff;
      past_end_b_ff <= past_end_a_ff;
      rom_data_ff   <= GammaRom[index_ff];
   end

   // Pick the curved or the straight ratio.
   always_comb begin
      out_valid = valid_b_ff;
      out_tag   = tag_b_ff;
      if (!gamma_curve) begin
         out_ratio = ratio_b_ff;
      end else if (past_end_b_ff) begin
         out_ratio = RatioOne;
      end else begin
         out_ratio = {1'b0, rom_data_ff};
      end
   end

endmodule

FILE: rtl/core/ifcm_color.sv
// Four-segment black-red-yellow-cyan-white color ramp and special-value colors.
// Two stages: segment slope product, then channel levels; depends on ifcm_pkg.
module ifcm_color
   import ifcm_pkg::*;
#(
   parameter int FRACTION_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  ifcm_tag_type             in_tag,
   input  logic [FRACTION_BITS:0]   in_ratio,
   output logic                     out_strobe,
   output logic [CHANNEL_WIDTH-1:0] out_red,
   output logic [CHANNEL_WIDTH-1:0] out_green,
   output logic [CHANNEL_WIDTH-1:0] out_blue
);

   localparam int RatioWidth   = FRACTION_BITS + 1;
   localparam int QuarterWidth = FRACTION_BITS - 2;
   localparam int ProdWidth    = RatioWidth + SLOPE_WIDTH;

   localparam logic [RatioWidth-1:0] ThreeQuarter = RatioWidth'(3) << QuarterWidth;
   localparam logic [ProdWidth-1:0]  SlopeScale   = ProdWidth'(COLOR_SLOPE);
   localparam logic [ProdWidth-1:0]  FullScale    = ProdWidth'(CHANNEL_FULL) << FRACTION_BITS;
   localparam logic [LEVEL_WIDTH-1:0] LevelFull   = LEVEL_WIDTH'(CHANNEL_FULL);

   ifcm_segment_type      segment_in;
   logic [RatioWidth-1:0] delta;
   logic [ProdWidth-1:0]  prod_in;

   logic                 valid_ff;
   ifcm_tag_type         tag_ff;
   ifcm_segment_type     segment_ff;
   logic [ProdWidth-1:0] prod_ff;

   logic [LEVEL_WIDTH-1:0]   level;
   logic [ProdWidth-1:0]     fall_full;
   logic [CHANNEL_WIDTH-1:0] rise;
   logic [CHANNEL_WIDTH-1:0] fall;
   logic [CHANNEL_WIDTH-1:0] rise_sat;
   logic [CHANNEL_WIDTH-1:0] red_in;
   logic [CHANNEL_WIDTH-1:0] green_in;
   logic [CHANNEL_WIDTH-1:0] blue_in;

   logic                     strobe_ff;
   logic [CHANNEL_WIDTH-1:0] red_ff;
   logic [CHANNEL_WIDTH-1:0] green_ff;
   logic [CHANNEL_WIDTH-1:0] blue_ff;

   // Segment from the top ratio bits, offset into the segment, and its slope product.
   always_comb begin
      unique case (in_ratio[FRACTION_BITS:QuarterWidth])
         3'd0:    segment_in = SEG_RED_RISE;
         3'd1:    segment_in = SEG_GREEN_RISE;
         3'd2:    segment_in = SEG_BLUE_RISE;
         default: segment_in = SEG_WHITE_RISE;
      endcase
      if (segment_in == SEG_WHITE_RISE) begin
         delta = in_ratio - ThreeQuarter;
      end else begin
         delta = RatioWidth'(in_ratio[QuarterWidth-1:0]);
      end
      prod_in = ProdWidth'(delta) * SlopeScale;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         valid_ff  <= in_valid;
         strobe_ff <= valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff     <= in_tag;
      segment_ff <= segment_in;
      prod_ff    <= prod_in;
   end

   // Channel levels per segment; not-a-number wins over infinite.
   always_comb begin
      level     = prod_ff[ProdWidth-1:FRACTION_BITS];
      rise      = level[CHANNEL_WIDTH-1:0];
      fall_full = FullScale - prod_ff;
      fall      = fall_full[FRACTION_BITS +: CHANNEL_WIDTH];
      rise_sat  = (level > LevelFull) ? CHANNEL_FULL : rise;
      unique case (segment_ff)
         SEG_RED_RISE: begin
            red_in   = rise;
            green_in = CHANNEL_ZERO;
            blue_in  = CHANNEL_ZERO;
         end
         SEG_GREEN_RISE: begin
            red_in   = CHANNEL_FULL;
            green_in = rise;
            blue_in  = CHANNEL_ZERO;
         end
         SEG_BLUE_RISE: begin
            red_in   = fall;
            green_in = CHANNEL_FULL;
            blue_in  = rise;
         end
         SEG_WHITE_RISE: begin
            red_in   = rise_sat;
            green_in = CHANNEL_FULL;
            blue_in  = CHANNEL_FULL;
         end
         default: begin
            red_in   = CHANNEL_ZERO;
            green_in = CHANNEL_ZERO;
            blue_in  = CHANNEL_ZERO;
         end
      endcase
      if (tag_ff.is_nan) begin
         red_in   = CHANNEL_ZERO;
         green_in = CHANNEL_FULL;
         blue_in  = CHANNEL_FULL;
      end else if (tag_ff.is_inf) begin
         red_in   = CHANNEL_FULL;
         green_in = CHANNEL_FULL;
         blue_in  = CHANNEL_FULL;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

   assign out_strobe = strobe_ff;
   assign out_red    = red_ff;
   assign out_green  = green_ff;
   assign out_blue   = blue_ff;

endmodule

FILE: rtl/core/intensity_false_color_map_unit.sv
// Top level of the intensity false-color map: register port and pixel pipeline.
// Depends on ifcm_pkg, ifcm_div, ifcm_gamma and ifcm_color.
//
// The unit takes one pixel on every clock (busy stays low) and returns its color
// on a one-cycle rsp_strobe; results leave in the order the pixels came in and
// cannot be held off. The pipeline is the divider, which resolves one ratio bit per
// pipeline stage, followed by the two-stage gamma table and the two-stage color ramp.
// Write max_intensity and gamma_curve only while no pixel is in flight.
module intensity_false_color_map_unit
   import ifcm_pkg::*;
#(
   parameter int FRACTION_BITS     = 16,
   parameter int GAMMA_TABLE_DEPTH = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [INTENSITY_WIDTH-1:0] req_intensity,
   input  logic                       req_not_a_number,
   input  logic                       req_infinite,
   output logic                       rsp_strobe,
   output logic [CHANNEL_WIDTH-1:0]   rsp_red,
   output logic [CHANNEL_WIDTH-1:0]   rsp_green,
   output logic [CHANNEL_WIDTH-1:0]   rsp_blue,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [CSR_DATA_WIDTH-1:0]  prdata,
   output logic                       pready
);

   logic [MAX_WIDTH-1:0] max_intensity_ff;
   logic                 gamma_curve_ff;
   ifcm_csr_index_type   csr_index;
   logic                 csr_write;

   ifcm_tag_type                 req_tag;
   logic                         div_valid;
   ifcm_tag_type                 div_tag;
   logic [FRACTION_BITS:0]       div_ratio;
   logic                         gamma_valid;
   ifcm_tag_type                 gamma_tag;
   logic [FRACTION_BITS:0]       gamma_ratio;

   // Register port: a write completes in the access cycle.
   assign pready    = 1'b1;
   assign csr_index = ifcm_csr_index_type'(paddr[2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_intensity_ff <= MAX_WIDTH'(1);
         gamma_curve_ff   <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MAX_INTENSITY: max_intensity_ff <= pwdata[MAX_WIDTH-1:0];
            CSR_GAMMA_CURVE:   gamma_curve_ff   <= pwdata[0];
            default:           gamma_curve_ff   <= gamma_curve_ff;
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      unique case (csr_index)
         CSR_MAX_INTENSITY: prdata = CSR_DATA_WIDTH'(max_intensity_ff);
         CSR_GAMMA_CURVE:   prdata = CSR_DATA_WIDTH'(gamma_curve_ff);
         default:           prdata = '0;
      endcase
   end

   // The pipeline never stalls, so a transaction is taken on every cycle.
   assign busy           = 1'b0;
   assign req_tag.is_nan = req_not_a_number;
   assign req_tag.is_inf = req_infinite;

   ifcm_div #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_div (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (start && !busy),
      .in_tag       (req_tag),
      .in_intensity (req_intensity),
      .max_intensity(max_intensity_ff),
      .out_valid    (div_valid),
      .out_tag      (div_tag),
      .out_ratio    (div_ratio)
   );

   ifcm_gamma #(
      .FRACTION_BITS    (FRACTION_BITS),
      .GAMMA_TABLE_DEPTH(GAMMA_TABLE_DEPTH)
   ) u_gamma (
      .clock      (clock),
      .reset      (reset),
      .gamma_curve(gamma_curve_ff),
      .in_valid   (div_valid),
      .in_tag     (div_tag),
      .in_ratio   (div_ratio),
      .out_valid  (gamma_valid),
      .out_tag    (gamma_tag),
      .out_ratio  (gamma_ratio)
   );

   ifcm_color #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_color (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (gamma_valid),
      .in_tag    (gamma_tag),
      .in_ratio  (gamma_ratio),
      .out_strobe(rsp_strobe),
      .out_red   (rsp_red),
      .out_green (rsp_green),
      .out_blue  (rsp_blue)
   );

endmodule

FILE: rtl/core/ifcm_monitor.sv
// Port-level assertions for the intensity false-color map unit, bound to the top level.
// Depends on ifcm_pkg and intensity_false_color_map_unit.
module ifcm_monitor
   import ifcm_pkg::*;
#(
   parameter int FRACTION_BITS = 16
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       req_not_a_number,
   input logic                       rsp_strobe,
   input logic [CHANNEL_WIDTH-1:0]   rsp_red,
   input logic [CHANNEL_WIDTH-1:0]   rsp_green,
   input logic [CHANNEL_WIDTH-1:0]   rsp_blue
);

   localparam int Latency = FRACTION_BITS + 5;

   // Every accepted transaction produces a result after the fixed latency.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##Latency rsp_strobe)
      else $error("accepted transaction produced no result");

   // No result appears without a transaction accepted the latency earlier.
   a_no_spurious_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, Latency))
      else $error("result without matching transaction");

   // A not-a-number pixel comes out cyan.
   a_nan_is_cyan: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_not_a_number) |-> ##Latency
         (rsp_red == CHANNEL_ZERO && rsp_green == CHANNEL_FULL && rsp_blue == CHANNEL_FULL))
      else $error("not-a-number pixel is not cyan");

   // Blue rises only once green is saturated.
   a_ramp_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_green != CHANNEL_FULL) |-> rsp_blue == CHANNEL_ZERO)
      else $error("blue set before green saturated");

endmodule

bind intensity_false_color_map_unit ifcm_monitor #(
   .FRACTION_BITS(FRACTION_BITS)
) u_ifcm_monitor (.*);
